>>> rtl/qrbm_pkg.sv
`timescale 1ns / 1ps

package qrbm_pkg;

    localparam logic [3:0] MODE_NIB   = 4'h4;
    localparam logic [7:0] PAD_FIRST  = 8'hEC;
    localparam logic [7:0] PAD_SECOND = 8'h11;
    localparam logic [7:0] MAX_LEN    = 8'd106;

    localparam logic [6:0] CAP_V1 = 7'd17;
    localparam logic [6:0] CAP_V2 = 7'd32;
    localparam logic [6:0] CAP_V3 = 7'd53;
    localparam logic [6:0] CAP_V4 = 7'd78;
    localparam logic [6:0] CAP_V5 = 7'd106;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] msg_length;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] codeword;
        logic [2:0] version_number;
        logic       length_error;
        logic       final_codeword;
    } result_t;

    // One nibble of the symbol stream, from the sequencer to the assembler.
    typedef struct packed {
        logic       valid;
        logic [3:0] nib;
        logic       close;
        logic       final_cw;
        logic       err;
        logic [2:0] version;
    } nib_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MODE,
        S_LHI,
        S_LLO,
        S_DHI,
        S_DLO,
        S_TERM,
        S_PAD
    } state_t;

    function automatic logic [2:0] pick_version(logic [7:0] len);
        logic [2:0] v;
        if (len == 8'd0 || len > MAX_LEN)
            v = 3'd0;
        else if (len <= {1'b0, CAP_V1})
            v = 3'd1;
        else if (len <= {1'b0, CAP_V2})
            v = 3'd2;
        else if (len <= {1'b0, CAP_V3})
            v = 3'd3;
        else if (len <= {1'b0, CAP_V4})
            v = 3'd4;
        else
            v = 3'd5;
        return v;
    endfunction

    function automatic logic [6:0] capacity_of(logic [2:0] v);
        logic [6:0] c;
        case (v)
            3'd1:    c = CAP_V1;
            3'd2:    c = CAP_V2;
            3'd3:    c = CAP_V3;
            3'd4:    c = CAP_V4;
            3'd5:    c = CAP_V5;
            default: c = 7'd0;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/qr_byte_mode_codeword_builder_core.sv
`timescale 1ns / 1ps
// Channel   Signals                              Payload
// -------   ----------------------------------   ---------------------------------
// item      item_valid, item_stall, item         data_byte, msg_length, last_byte
// result    result_valid, result_stall, result   codeword, version_number,
//                                                length_error, final_codeword
//
// One nibble of the symbol stream moves into the assembler per cycle, unless a
// result stall holds a closing nibble. A middle data byte gives two nibbles, the
// first byte of a message five; the last byte adds the terminator nibble, two
// nibbles per pad codeword and an idle state before the next request is taken.
// A rejected length gives one error result, and a dropped byte none.
// rst_n clears the control state at once; no clearing pass is needed.
// A result stall holds the nibble stream at the next closing nibble only.

module qr_byte_mode_codeword_builder_core
    import qrbm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    nib_t emit;
    logic take;

    qrbm_nibble_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .emit       (emit),
        .take       (take)
    );

    qrbm_cw_asm u_asm (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit         (emit),
        .take         (take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> rtl/qrbm_nibble_seq.sv
`timescale 1ns / 1ps

module qrbm_nibble_seq
    import qrbm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_stall,
    input  item_t  item,
    output nib_t   emit,
    input  logic   take
);

    state_t     state_reg, state_next;
    logic       msg_open_reg, msg_open_next;
    logic       dropping_reg, dropping_next;
    logic       end_reg, end_next;
    logic [6:0] count_reg, count_next;
    logic [6:0] pads_reg, pads_next;
    logic [1:0] pad_idx_reg, pad_idx_next;
    logic [2:0] version_reg, version_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] data_reg, data_next;
    logic [7:0] pad_byte;
    logic [2:0] pick_v;
    logic       accept_ok;

    assign pick_v   = pick_version(item.msg_length);
    assign pad_byte = pad_idx_reg[1] ? PAD_SECOND : PAD_FIRST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            msg_open_reg <= 1'b0;
            dropping_reg <= 1'b0;
            end_reg      <= 1'b0;
            count_reg    <= 7'd0;
            pads_reg     <= 7'd0;
            pad_idx_reg  <= 2'd0;
            version_reg  <= 3'd0;
        end
        else
        begin
            state_reg    <= state_next;
            msg_open_reg <= msg_open_next;
            dropping_reg <= dropping_next;
            end_reg      <= end_next;
            count_reg    <= count_next;
            pads_reg     <= pads_next;
            pad_idx_reg  <= pad_idx_next;
            version_reg  <= version_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        data_reg <= data_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        msg_open_next = msg_open_reg;
        dropping_next = dropping_reg;
        end_next      = end_reg;
        count_next    = count_reg;
        pads_next     = pads_reg;
        pad_idx_next  = pad_idx_reg;
        version_next  = version_reg;
        len_next      = len_reg;
        data_next     = data_reg;
        accept_ok     = 1'b0;
        emit          = '0;
        emit.version  = version_reg;

        case (state_reg)
            S_IDLE:
            begin
                accept_ok = 1'b1;
            end
            S_ERR:
            begin
                emit.valid    = 1'b1;
                emit.close    = 1'b1;
                emit.final_cw = 1'b1;
                emit.err      = 1'b1;
                emit.version  = 3'd0;
                if (take)
                    state_next = S_IDLE;
            end
            S_MODE:
            begin
                emit.valid = 1'b1;
                emit.nib   = MODE_NIB;
                if (take)
                    state_next = S_LHI;
            end
            S_LHI:
            begin
                emit.valid = 1'b1;
                emit.nib   = len_reg[7:4];
                emit.close = 1'b1;
                if (take)
                    state_next = S_LLO;
            end
            S_LLO:
            begin
                emit.valid = 1'b1;
                emit.nib   = len_reg[3:0];
                if (take)
                    state_next = S_DHI;
            end
            S_DHI:
            begin
                emit.valid = 1'b1;
                emit.nib   = data_reg[7:4];
                emit.close = 1'b1;
                if (take)
                begin
                    count_next = 7'(count_reg + 7'd1);
                    end_next   = (7'(count_reg + 7'd1) == len_reg[6:0]);
                    state_next = S_DLO;
                end
            end
            S_DLO:
            begin
                // Low nibble waits in the assembler for next high or terminator.
                emit.valid = 1'b1;
                emit.nib   = data_reg[3:0];
                if (end_reg)
                begin
                    if (take)
                        state_next = S_TERM;
                end
                else
                begin
                    accept_ok = take;
                    if (take)
                        state_next = S_IDLE;
                end
            end
            S_TERM:
            begin
                emit.valid    = 1'b1;
                emit.nib      = 4'h0;
                emit.close    = 1'b1;
                emit.final_cw = (pads_reg == 7'd0);
                if (take)
                begin
                    pad_idx_next = 2'd0;
                    if (pads_reg == 7'd0)
                    begin
                        msg_open_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                    else
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                emit.valid    = 1'b1;
                emit.nib      = pad_idx_reg[0] ? pad_byte[3:0] : pad_byte[7:4];
                emit.close    = pad_idx_reg[0];
                emit.final_cw = pad_idx_reg[0] && (pads_reg == 7'd1);
                if (take)
                begin
                    pad_idx_next = 2'(pad_idx_reg + 2'd1);
                    if (pad_idx_reg[0])
                    begin
                        pads_next = 7'(pads_reg - 7'd1);
                        if (pads_reg == 7'd1)
                        begin
                            msg_open_next = 1'b0;
                            state_next    = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (accept_ok && item_valid)
        begin
            data_next = item.data_byte;
            if (dropping_reg)
            begin
                // Discard the rest of a message whose length was rejected.
                if (item.last_byte)
                    dropping_next = 1'b0;
                state_next = S_IDLE;
            end
            else if (!msg_open_reg)
            begin
                if (pick_v == 3'd0)
                begin
                    dropping_next = !item.last_byte;
                    state_next    = S_ERR;
                end
                else
                begin
                    version_next  = pick_v;
                    len_next      = item.msg_length;
                    pads_next     = 7'(capacity_of(pick_v) - item.msg_length[6:0]);
                    count_next    = 7'd0;
                    msg_open_next = 1'b1;
                    state_next    = S_MODE;
                end
            end
            else
                state_next = S_DHI;
        end
    end

    assign item_stall = !accept_ok;

`ifndef SYNTHESIS
    a_open_has_version: assert property (@(posedge clk) disable iff (!rst_n)
        msg_open_reg |-> (version_reg != 3'd0))
        else $error("open message without a version");

    a_pad_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAD) |-> (pads_reg != 7'd0))
        else $error("pad state with no pads left");

    a_end_to_term: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DHI && take && end_next) |=> (state_reg == S_DLO && end_reg))
        else $error("message end not carried to the low nibble");

    a_err_not_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERR) |-> !msg_open_reg)
        else $error("error request inside an open message");
`endif

endmodule

>>> rtl/qrbm_cw_asm.sv
`timescale 1ns / 1ps

module qrbm_cw_asm
    import qrbm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  nib_t    emit,
    output logic    take,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic       result_valid_reg, result_valid_next;
    result_t    result_reg, result_next;
    logic [3:0] lo_reg, lo_next;
    logic       slot_free;

    // A closing nibble needs the output slot; an opening nibble only shifts in.
    assign slot_free = !result_valid_reg || !result_stall;
    assign take      = emit.valid && (!emit.close || slot_free);

    always_comb
    begin
        lo_next           = lo_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (take)
        begin
            if (emit.close)
            begin
                result_next.codeword       = emit.err ? 8'h00 : {lo_reg, emit.nib};
                result_next.version_number = emit.version;
                result_next.length_error   = emit.err;
                result_next.final_codeword = emit.final_cw;
                result_valid_next          = 1'b1;
            end
            else
                lo_next = emit.nib;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
